>>> design/rrs2_pkg.sv
package rrs2_pkg;

    localparam int SLOTS_PER_GROUP = 16;
    localparam int TABLE_SIZE      = 2 * SLOTS_PER_GROUP;
    localparam int IDX_W           = $clog2(TABLE_SIZE);
    localparam int SLOT_W          = 4;
    localparam int DESC_W          = 13;
    localparam int TURN_W          = 3;
    localparam int AGE_W           = 6;
    localparam int COUNTER_TOP     = 3;
    localparam int AGE_LIMIT       = 50;

    localparam logic [1:0] OP_NEXT   = 2'd0;
    localparam logic [1:0] OP_SPAWN  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic CFG_GROUP0_MAIN = 1'b0;
    localparam logic CFG_GROUP1_MAIN = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic              group;
        logic [SLOT_W-1:0] slot;
        logic [DESC_W-1:0] descriptor;
    } t_in_item;

    typedef struct packed {
        logic [DESC_W-1:0] chosen_descriptor;
        logic              chosen_group;
        logic              is_main;
        logic [SLOT_W-1:0] chosen_slot;
        logic [TURN_W-1:0] turn_count;
        logic [AGE_W-1:0]  age;
    } t_out_item;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [DESC_W-1:0] descriptor;
        logic [TURN_W-1:0] turn_count;
        logic [AGE_W-1:0]  age;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    typedef struct packed {
        logic take_next;
        logic take_update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] operation;
        logic       slot_ok;
    } t_status;

endpackage

>>> design/rrs2_ram.sv
module rrs2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rrs2_ctrl.sv
module rrs2_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rrs2_pkg::t_status i_status,
    output rrs2_pkg::t_cmd  o_cmd
);
    import rrs2_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic accept;
    logic out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state           = r_state;
        o_cmd.take_next   = 1'b0;
        o_cmd.take_update = 1'b0;
        o_cmd.finish      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_status.operation == OP_NEXT) begin
                        o_cmd.take_next = 1'b1;
                        n_state         = S_FIN;
                    end else if (i_status.operation inside {OP_SPAWN, OP_REMOVE}) begin
                        o_cmd.take_update = i_status.slot_ok;
                    end
                end
            end
            S_FIN: begin
                // hold the memory read until the output register frees up
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/rrs2_datapath.sv
module rrs2_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrs2_pkg::t_in_item            i_in_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [rrs2_pkg::DESC_W-1:0]   i_cfg_data,
    input  rrs2_pkg::t_cmd                i_cmd,
    output rrs2_pkg::t_status             o_status,
    output rrs2_pkg::t_out_item           o_out_item
);
    import rrs2_pkg::*;

    function automatic logic [TURN_W-1:0] step_counter(input logic [TURN_W-1:0] c);
        logic [TURN_W-1:0] res;
        res = (c > TURN_W'(COUNTER_TOP)) ? '0 : TURN_W'(c + TURN_W'(1));
        return res;
    endfunction

    function automatic logic [AGE_W-1:0] step_age(input logic [AGE_W-1:0] a);
        logic [AGE_W-1:0] res;
        res = (a >= AGE_W'(AGE_LIMIT)) ? AGE_W'(AGE_LIMIT) : AGE_W'(a + AGE_W'(1));
        return res;
    endfunction

    logic [TABLE_SIZE-1:0]      r_alive;
    logic [TABLE_SIZE-1:0]      n_alive;
    logic [TABLE_SIZE-1:0]      r_seen;
    logic [TABLE_SIZE-1:0]      n_seen;
    logic                       r_last_grp;
    logic [TURN_W-1:0]          r_main_turn [2];
    logic [DESC_W-1:0]          r_cfg_main0;
    logic [DESC_W-1:0]          r_cfg_main1;
    logic                       r_hit;
    logic                       r_grp;
    logic [SLOT_W-1:0]          r_slot;
    logic [IDX_W-1:0]           r_idx;
    t_out_item                  r_out_item;

    logic                       next_grp;
    logic [SLOTS_PER_GROUP-1:0] avail;
    logic                       pick_hit;
    logic [SLOT_W-1:0]          pick_slot;
    logic [IDX_W-1:0]           pick_idx;
    logic [IDX_W-1:0]           upd_idx;
    int                         base;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    t_slot_word                 ram_wdata;
    t_slot_word                 ram_rdata;
    logic [SLOT_WORD_W-1:0]     ram_rdata_raw;
    logic [TURN_W-1:0]          new_turn;
    logic [AGE_W-1:0]           new_age;
    logic [TURN_W-1:0]          main_turn_next;

    assign o_status.operation = i_in_item.operation;
    assign o_status.slot_ok   = (32'(i_in_item.slot) < SLOTS_PER_GROUP);

    assign next_grp = ~r_last_grp;
    assign avail    = next_grp
                    ? (r_alive[TABLE_SIZE-1:SLOTS_PER_GROUP] &
                       ~r_seen[TABLE_SIZE-1:SLOTS_PER_GROUP])
                    : (r_alive[SLOTS_PER_GROUP-1:0] & ~r_seen[SLOTS_PER_GROUP-1:0]);

    // lowest live, unseen slot wins
    always_comb begin
        pick_hit  = 1'b0;
        pick_slot = '0;
        for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
            if (avail[i]) begin
                pick_hit  = 1'b1;
                pick_slot = SLOT_W'(i);
            end
        end
    end

    assign pick_idx = IDX_W'(IDX_W'(next_grp) * IDX_W'(SLOTS_PER_GROUP) + IDX_W'(pick_slot));
    assign upd_idx  = IDX_W'(IDX_W'(i_in_item.group) * IDX_W'(SLOTS_PER_GROUP)
                           + IDX_W'(i_in_item.slot));
    assign base     = next_grp ? SLOTS_PER_GROUP : 0;

    always_comb begin
        n_alive = r_alive;
        n_seen  = r_seen;
        if (i_cmd.take_update) begin
            if (i_in_item.operation == OP_SPAWN) begin
                n_alive[upd_idx] = 1'b1;
                n_seen[upd_idx]  = 1'b0;
            end else begin
                n_alive[upd_idx] = 1'b0;
            end
        end
        if (i_cmd.take_next) begin
            if (pick_hit) begin
                n_seen[pick_idx] = 1'b1;
            end else begin
                // round over: clear the whole group
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    if (i >= base && i < base + SLOTS_PER_GROUP) begin
                        n_seen[i] = 1'b0;
                    end
                end
            end
        end
    end

    assign ram_rdata      = t_slot_word'(ram_rdata_raw);
    assign new_turn       = step_counter(ram_rdata.turn_count);
    assign new_age        = step_age(ram_rdata.age);
    assign main_turn_next = step_counter(r_main_turn[r_grp]);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = upd_idx;
        ram_wdata.descriptor = i_in_item.descriptor;
        ram_wdata.turn_count = '0;
        ram_wdata.age        = '0;
        if (i_cmd.take_update && i_in_item.operation == OP_SPAWN) begin
            ram_we = 1'b1;
        end else if (i_cmd.finish && r_hit) begin
            // write back the stepped counters
            ram_we               = 1'b1;
            ram_waddr            = r_idx;
            ram_wdata.descriptor = ram_rdata.descriptor;
            ram_wdata.turn_count = new_turn;
            ram_wdata.age        = new_age;
        end
    end

    rrs2_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (SLOT_WORD_W'(ram_wdata)),
        .i_re    (i_cmd.take_next),
        .i_raddr (pick_idx),
        .o_rdata (ram_rdata_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive        <= '0;
            r_seen         <= '0;
            r_last_grp     <= 1'b1;
            r_main_turn[0] <= '0;
            r_main_turn[1] <= '0;
            r_cfg_main0    <= '0;
            r_cfg_main1    <= '0;
        end else begin
            r_alive <= n_alive;
            r_seen  <= n_seen;
            if (i_cmd.take_next) begin
                r_last_grp <= next_grp;
            end
            if (i_cmd.finish && !r_hit) begin
                r_main_turn[r_grp] <= main_turn_next;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_GROUP0_MAIN) begin
                    r_cfg_main0 <= i_cfg_data;
                end else begin
                    r_cfg_main1 <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_next) begin
            r_hit  <= pick_hit;
            r_grp  <= next_grp;
            r_slot <= pick_slot;
            r_idx  <= pick_idx;
        end
        if (i_cmd.finish) begin
            r_out_item.chosen_group <= r_grp;
            if (r_hit) begin
                r_out_item.chosen_descriptor <= ram_rdata.descriptor;
                r_out_item.is_main           <= 1'b0;
                r_out_item.chosen_slot       <= r_slot;
                r_out_item.turn_count        <= new_turn;
                r_out_item.age               <= new_age;
            end else begin
                r_out_item.chosen_descriptor <= r_grp ? r_cfg_main1 : r_cfg_main0;
                r_out_item.is_main           <= 1'b1;
                r_out_item.chosen_slot       <= '0;
                r_out_item.turn_count        <= main_turn_next;
                r_out_item.age               <= '0;
            end
        end
    end

    assign o_out_item = r_out_item;

endmodule

>>> design/two_group_round_robin_scheduler_core.sv
// Two-group round-robin scheduler. Each next request serves the other group and
// returns its lowest live slot not yet seen this round, or the group's main task
// once every live slot has been seen (which also starts a new round). Spawn and
// remove beats update the slot table and give no result. A next request picks
// the slot from the flag registers and reads the slot memory (descriptor, turn
// counter and age per slot), then writes a slot's stepped counters back and loads
// the output register. Input is not taken while a next request waits for the
// output register to free up. Main descriptors must be written through the
// configuration port only while the block is idle; the block does not check it.
module two_group_round_robin_scheduler_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rrs2_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rrs2_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [rrs2_pkg::DESC_W-1:0] i_cfg_data
);
    import rrs2_pkg::*;

    t_cmd    cmd;
    t_status status;

    rrs2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rrs2_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

endmodule

>>> design/rrs2_checker.sv
module rrs2_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input rrs2_pkg::t_in_item          i_in_item,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input rrs2_pkg::t_out_item         o_out_item
);
    import rrs2_pkg::*;

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result beat dropped or changed while stalled");

    // taking a next request closes the input
    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.operation == OP_NEXT) |=> !o_in_ready)
        else $error("input taken straight after a next request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_main_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_main) |->
        (o_out_item.chosen_slot == '0 && o_out_item.age == '0))
        else $error("main task result carries slot or age");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.turn_count <= TURN_W'(COUNTER_TOP + 1) &&
                         o_out_item.age <= AGE_W'(AGE_LIMIT)))
        else $error("turn count or age out of range");

endmodule

bind two_group_round_robin_scheduler_core rrs2_checker u_rrs2_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> bench/two_group_round_robin_scheduler_core_tb.sv
module two_group_round_robin_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrs2_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NO_BEAT_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;

    // one scripted beat: the input, whether a pick is typed in, and that pick
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item pick;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // straight after reset both groups have only their main task
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h1FFF, 1'b0, 1'b1, 4'd0,  3'd1, 6'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h0000, 1'b1, 1'b1, 4'd0,  3'd1, 6'd0},
        {OP_UNUSED,  1'b1, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_SPAWN,   1'b0, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_SPAWN,   1'b0, 4'd0,  13'h0000, 1'b0, 28'd0},
        {OP_SPAWN,   1'b1, 4'd7,  13'h0AAA, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h0000, 1'b0, 1'b0, 4'd0,  3'd1, 6'd1},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h0AAA, 1'b1, 1'b0, 4'd7,  3'd1, 6'd1},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h1FFF, 1'b0, 1'b0, 4'd15, 3'd1, 6'd1},
        // every live slot seen: fall back to main and start a new round
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h0000, 1'b1, 1'b1, 4'd0,  3'd2, 6'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b1, 13'h1FFF, 1'b0, 1'b1, 4'd0,  3'd2, 6'd0},
        {OP_REMOVE,  1'b0, 4'd0,  13'h1FFF, 1'b0, 28'd0},
        {OP_NEXT,    1'b1, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd5,  13'h0555, 1'b0, 28'd0},
        {OP_NEXT,    1'b1, 4'd10, 13'h1AAA, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b0, 28'd0},
        {OP_NEXT,    1'b1, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b0, 28'd0},
        {OP_NEXT,    1'b1, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b0, 28'd0},
        {OP_NEXT,    1'b1, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b0, 28'd0},
        // turn counters pass 4 here and wrap to 0
        {OP_NEXT,    1'b1, 4'd15, 13'h1FFF, 1'b0, 28'd0},
        {OP_SPAWN,   1'b1, 4'd7,  13'h1555, 1'b0, 28'd0},
        {OP_NEXT,    1'b0, 4'd0,  13'h0000, 1'b0, 28'd0}
    };

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    t_in_item        in_item;
    logic            out_valid;
    logic            out_ready;
    t_out_item       out_item;
    logic            cfg_we;
    logic            cfg_index;
    logic [DESC_W-1:0] cfg_data;

    // scheduler state as the bench predicts it
    logic              sched_alive [TABLE_SIZE];
    logic              sched_seen  [TABLE_SIZE];
    logic [TURN_W-1:0] sched_turn  [TABLE_SIZE];
    logic [AGE_W-1:0]  sched_age   [TABLE_SIZE];
    logic [DESC_W-1:0] sched_desc  [TABLE_SIZE];
    logic [TURN_W-1:0] main_turn   [2];
    logic [DESC_W-1:0] main_desc   [2];
    logic              last_group;

    t_out_item pending_picks [$];

    int mismatches;
    int beats_sent;
    int picks_checked;
    int main_picks;
    int top_age;
    int idle_pct;
    int stall_pct;

    two_group_round_robin_scheduler_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic logic [TURN_W-1:0] bump_turn(input logic [TURN_W-1:0] c);
        return (c > COUNTER_TOP) ? '0 : c + 1'b1;
    endfunction

    task automatic schedule_step(input t_in_item it, output logic produced,
                                 output t_out_item pick);
        int idx;
        int base;
        int hit;
        logic g;
        produced = 1'b0;
        pick     = '0;
        hit      = -1;
        idx      = (it.group ? SLOTS_PER_GROUP : 0) + int'(it.slot);
        case (it.operation)
            OP_SPAWN: begin
                sched_alive[idx] = 1'b1;
                sched_seen[idx]  = 1'b0;
                sched_turn[idx]  = '0;
                sched_age[idx]   = '0;
                sched_desc[idx]  = it.descriptor;
            end
            OP_REMOVE: begin
                sched_alive[idx] = 1'b0;
            end
            OP_NEXT: begin
                g          = ~last_group;
                last_group = g;
                base       = g ? SLOTS_PER_GROUP : 0;
                for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
                    if (hit < 0 && sched_alive[base + i] && !sched_seen[base + i]) begin
                        hit = i;
                    end
                end
                pick.chosen_group = g;
                if (hit >= 0) begin
                    idx = base + hit;
                    sched_seen[idx] = 1'b1;
                    sched_turn[idx] = bump_turn(sched_turn[idx]);
                    sched_age[idx]  = (sched_age[idx] >= AGE_LIMIT) ? AGE_W'(AGE_LIMIT)
                                                                    : sched_age[idx] + 1'b1;
                    pick.chosen_descriptor = sched_desc[idx];
                    pick.is_main           = 1'b0;
                    pick.chosen_slot       = SLOT_W'(hit);
                    pick.turn_count        = sched_turn[idx];
                    pick.age               = sched_age[idx];
                end else begin
                    for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
                        sched_seen[base + i] = 1'b0;
                    end
                    main_turn[g] = bump_turn(main_turn[g]);
                    pick.chosen_descriptor = main_desc[g];
                    pick.is_main           = 1'b1;
                    pick.turn_count        = main_turn[g];
                end
                produced = 1'b1;
            end
            default: begin
                // unused operation: drop it
            end
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the beat, or later when an idle gap follows
    task automatic send_beat(input t_in_item it, input logic typed,
                             input t_out_item typed_pick);
        logic produced;
        t_out_item pick;
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        schedule_step(it, produced, pick);
        if (produced) begin
            pending_picks.push_back(typed ? typed_pick : pick);
        end
        beats_sent++;
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid = 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // hold the sender until every pick is back and the block has gone quiet
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (pending_picks.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_main_desc(input logic idx, input logic [DESC_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        main_desc[idx] = value;
    endtask

    function automatic t_in_item random_item(input logic ageing);
        t_in_item it;
        int unsigned roll;
        it.group      = 1'($urandom_range(0, 1));
        it.slot       = SLOT_W'($urandom_range(0, SLOTS_PER_GROUP - 1));
        it.descriptor = DESC_W'($urandom_range(0, (1 << DESC_W) - 1));
        roll          = $urandom_range(0, 99);
        if (ageing) begin
            it.operation = (roll < 92) ? OP_NEXT :
                           (roll < 95) ? OP_SPAWN :
                           (roll < 98) ? OP_REMOVE : OP_UNUSED;
            // keep group 0 down to its lone slot so that slot ages quickly
            if (it.operation == OP_SPAWN || it.operation == OP_REMOVE) begin
                it.group = 1'b1;
            end
        end else begin
            it.operation = (roll < 50) ? OP_NEXT :
                           (roll < 75) ? OP_SPAWN :
                           (roll < 95) ? OP_REMOVE : OP_UNUSED;
        end
        return it;
    endfunction

    // receiver
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_picks.size() == 0) begin
                note_mismatch($sformatf("pick with nothing expected: %h", out_item));
            end else begin
                want = pending_picks.pop_front();
                if (out_item.chosen_descriptor !== want.chosen_descriptor)
                    note_mismatch($sformatf("pick %0d descriptor %h, want %h", picks_checked,
                                            out_item.chosen_descriptor, want.chosen_descriptor));
                if (out_item.chosen_group !== want.chosen_group)
                    note_mismatch($sformatf("pick %0d group %b, want %b", picks_checked,
                                            out_item.chosen_group, want.chosen_group));
                if (out_item.is_main !== want.is_main)
                    note_mismatch($sformatf("pick %0d is_main %b, want %b", picks_checked,
                                            out_item.is_main, want.is_main));
                if (out_item.chosen_slot !== want.chosen_slot)
                    note_mismatch($sformatf("pick %0d slot %0d, want %0d", picks_checked,
                                            out_item.chosen_slot, want.chosen_slot));
                if (out_item.turn_count !== want.turn_count)
                    note_mismatch($sformatf("pick %0d turn %0d, want %0d", picks_checked,
                                            out_item.turn_count, want.turn_count));
                if (out_item.age !== want.age)
                    note_mismatch($sformatf("pick %0d age %0d, want %0d", picks_checked,
                                            out_item.age, want.age));
                if (want.is_main) main_picks++;
                if (int'(want.age) > top_age) top_age = int'(want.age);
            end
            picks_checked++;
        end
    end

    // watchdog: give up after a long stretch with no beat on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < NO_BEAT_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("no beat for %0d cycles, %0d picks outstanding", NO_BEAT_LIMIT,
                 pending_picks.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int phase_len;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_GROUP0_MAIN;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        mismatches    = 0;
        beats_sent    = 0;
        picks_checked = 0;
        main_picks    = 0;
        top_age       = 0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            sched_alive[i] = 1'b0;
            sched_seen[i]  = 1'b0;
            sched_turn[i]  = '0;
            sched_age[i]   = '0;
            sched_desc[i]  = '0;
        end
        main_turn[0] = '0;
        main_turn[1] = '0;
        main_desc[0] = '0;
        main_desc[1] = '0;
        last_group   = 1'b1;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        write_main_desc(CFG_GROUP0_MAIN, '1);
        write_main_desc(CFG_GROUP1_MAIN, '0);
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            send_beat(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].pick);
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_quiet();
            case (phase)
                0: begin
                    write_main_desc(CFG_GROUP0_MAIN, '0);
                    write_main_desc(CFG_GROUP1_MAIN, '1);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    write_main_desc(CFG_GROUP0_MAIN, DESC_W'($urandom));
                    write_main_desc(CFG_GROUP1_MAIN, DESC_W'($urandom));
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2: begin
                    write_main_desc(CFG_GROUP0_MAIN, DESC_W'($urandom));
                    write_main_desc(CFG_GROUP1_MAIN, DESC_W'($urandom));
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default: begin
                    write_main_desc(CFG_GROUP0_MAIN, 13'h0AAA);
                    write_main_desc(CFG_GROUP1_MAIN, 13'h1555);
                    idle_pct  = 35;
                    stall_pct = 35;
                end
            endcase
            phase_len = (phase == 0) ? 300 : 200;
            if (phase == 0) begin
                // clear group 0 down to slot 0, then let that slot age to its limit
                for (int s = 1; s < SLOTS_PER_GROUP; s++) begin
                    send_beat({OP_REMOVE, 1'b0, SLOT_W'(s), DESC_W'($urandom)}, 1'b0, '0);
                end
                send_beat({OP_SPAWN, 1'b0, SLOT_W'(0), DESC_W'($urandom)}, 1'b0, '0);
                phase_len = phase_len - SLOTS_PER_GROUP;
            end
            for (int n = 0; n < phase_len; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    in_valid = 1'b0;
                    while (pending_picks.size() != 0) @(negedge clk);
                end
                send_beat(random_item(phase == 0), 1'b0, '0);
            end
        end

        in_valid = 1'b0;
        while (pending_picks.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_picks.size() != 0) begin
            note_mismatch($sformatf("%0d picks never came", pending_picks.size()));
        end

        $display("%0d beats in, %0d picks checked (%0d main, %0d slot), oldest age %0d,",
                 beats_sent, picks_checked, main_picks, picks_checked - main_picks, top_age);
        $display("over four idle and stall mixes with main descriptors at both extremes");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
design/rrs2_pkg.sv
design/rrs2_ram.sv
design/rrs2_ctrl.sv
design/rrs2_datapath.sv
design/two_group_round_robin_scheduler_core.sv
design/rrs2_checker.sv
bench/two_group_round_robin_scheduler_core_tb.sv
